// ----- hw/rtl/bao_pkg.sv -----
// Shared constants and types for the bracket-aware operator search block.
// Used by the store, the character compare unit, the sequencer and the top level.
// Depends on nothing.
package bao_pkg;

	localparam int EXPR_DEPTH = 256;
	localparam int ADDR_W     = $clog2(EXPR_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int MAX_OP_LEN = 4;
	localparam int OP_IDX_W   = $clog2(MAX_OP_LEN);
	localparam int OP_LEN_W   = 3;
	localparam int OP_TEXT_W  = 32;
	localparam int CHAR_W     = 8;
	localparam int OFFSET_W   = 8;
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 4;
	localparam int REG_IDX_W  = 2;

	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

	localparam logic KIND_PAREN = 1'b0;
	localparam logic KIND_BRACK = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_OP_TEXT     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OP_LENGTH   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SEARCH_LAST = 2'd2;

	// Classification of the character just read from the store.
	typedef struct packed {
		logic op_eq;     // equals the selected operator character
		logic open_eq;   // opening bracket of the selected kind
		logic close_eq;  // closing bracket of the selected kind
		logic space_eq;
		logic lparen;
		logic lbrack;
	} cmp_flags_t;

	typedef struct packed {
		logic                valid;
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} seq_res_t;

endpackage

// ----- hw/rtl/bao_store.sv -----
// Expression store: single write port, single read port with registered read data.
// Depends on bao_pkg.
module bao_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bao_pkg::ADDR_W-1:0] waddr,
	input  logic [bao_pkg::CHAR_W-1:0] wdata,
	input  logic [bao_pkg::ADDR_W-1:0] raddr,
	output logic [bao_pkg::CHAR_W-1:0] rdata
);
	import bao_pkg::*;

	logic [CHAR_W-1:0] mem_q [EXPR_DEPTH];
	logic [CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bao_cmp.sv -----
// Character compare unit shared by every step of the search.
// Classifies one stored character against the operator and bracket characters.
// Depends on bao_pkg.
module bao_cmp (
	input  logic [bao_pkg::CHAR_W-1:0]    ch,
	input  logic [bao_pkg::OP_TEXT_W-1:0] op_text,
	input  logic [bao_pkg::OP_IDX_W-1:0]  op_idx,
	input  logic                          kind,
	output bao_pkg::cmp_flags_t           flags
);
	import bao_pkg::*;

	logic [CHAR_W-1:0] op_ch;
	logic [CHAR_W-1:0] open_ch;
	logic [CHAR_W-1:0] close_ch;

	always_comb begin
		op_ch          = op_text[CHAR_W*op_idx +: CHAR_W];
		open_ch        = (kind == KIND_BRACK) ? CH_LBRACK : CH_LPAREN;
		close_ch       = (kind == KIND_BRACK) ? CH_RBRACK : CH_RPAREN;
		flags.op_eq    = (ch == op_ch);
		flags.open_eq  = (ch == open_ch);
		flags.close_eq = (ch == close_ch);
		flags.space_eq = (ch == CH_SPACE);
		flags.lparen   = (ch == CH_LPAREN);
		flags.lbrack   = (ch == CH_LBRACK);
	end

endmodule

// ----- hw/rtl/bao_seq.sv -----
// Search sequencer: walks the stored expression one character read per cycle,
// forward for the first match or backward for the last, skipping bracketed blocks.
// Depends on bao_pkg; drives the store read address and the compare unit.
module bao_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bao_pkg::CNT_W-1:0]     len,
	input  logic [bao_pkg::OP_LEN_W-1:0]  op_n,
	input  logic                          search_last,
	input  bao_pkg::cmp_flags_t           flags,
	input  logic                          res_ack,
	output logic [bao_pkg::ADDR_W-1:0]    rd_addr,
	output logic [bao_pkg::OP_IDX_W-1:0]  op_idx,
	output logic                          kind,
	output logic                          idle,
	output bao_pkg::seq_res_t             res
);
	import bao_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE    = 14'b00000000000001,
		ST_START   = 14'b00000000000010,
		ST_FCHECK  = 14'b00000000000100,
		ST_FMATCH  = 14'b00000000001000,
		ST_FCLASS  = 14'b00000000010000,
		ST_FSKIP   = 14'b00000000100000,
		ST_FSPACE  = 14'b00000001000000,
		ST_BPRE    = 14'b00000010000000,
		ST_BKIND   = 14'b00000100000000,
		ST_BKRD    = 14'b00001000000000,
		ST_BDEPTH  = 14'b00010000000000,
		ST_BMSTART = 14'b00100000000000,
		ST_BMATCH  = 14'b01000000000000,
		ST_DONE    = 14'b10000000000000
	} seq_state_t;

	seq_state_t           st_q, st_d, kind_done_st;
	logic [CNT_W-1:0]     pos_q, pos_d, pos_inc, pos_dec, match_addr;
	logic [CNT_W-1:0]     depth_q, depth_d, depth_fwd, depth_back;
	logic [CNT_W-1:0]     len_q;
	logic [OP_LEN_W-1:0]  n_q;
	logic                 last_q;
	logic [OP_IDX_W-1:0]  idx_q, idx_d;
	logic                 kind_q, kind_d;
	logic                 pre_q, pre_d;
	logic                 found_q, found_d;
	logic                 idx_last;

	always_comb begin
		pos_inc    = pos_q + CNT_W'(1);
		pos_dec    = pos_q - CNT_W'(1);
		match_addr = pos_q + CNT_W'(idx_q) + CNT_W'(1);
		idx_last   = ({1'b0, idx_q} == (n_q - OP_LEN_W'(1)));
		// Forward skip: the opening bracket nests deeper; backward it is the reverse.
		depth_fwd  = flags.open_eq ? depth_q + CNT_W'(1) :
		             flags.close_eq ? depth_q - CNT_W'(1) : depth_q;
		depth_back = flags.open_eq ? depth_q - CNT_W'(1) :
		             flags.close_eq ? depth_q + CNT_W'(1) : depth_q;
		// After one bracket kind is handled backward, try the other, then resume.
		if (kind_q == KIND_PAREN) begin
			kind_done_st = ST_BKIND;
		end else begin
			kind_done_st = pre_q ? ST_BPRE : ST_BMSTART;
		end
	end

	always_comb begin
		st_d    = st_q;
		pos_d   = pos_q;
		depth_d = depth_q;
		idx_d   = idx_q;
		kind_d  = kind_q;
		pre_d   = pre_q;
		found_d = found_q;
		rd_addr = pos_q[ADDR_W-1:0];
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					st_d = ST_START;
				end
			end
			ST_START: begin
				pos_d   = '0;
				idx_d   = '0;
				found_d = 1'b0;
				kind_d  = KIND_PAREN;
				if (!last_q) begin
					st_d = ST_FCHECK;
				end else if (CNT_W'(n_q) > len_q) begin
					st_d = ST_DONE;
				end else begin
					pos_d = len_q;
					pre_d = 1'b1;
					st_d  = ST_BPRE;
				end
			end
			ST_FCHECK: begin
				if (({1'b0, pos_q} + (CNT_W + 1)'(n_q)) > {1'b0, len_q}) begin
					st_d = ST_DONE;
				end else begin
					idx_d = '0;
					st_d  = ST_FMATCH;
				end
			end
			ST_FMATCH: begin
				if (flags.op_eq) begin
					if (idx_last) begin
						found_d = 1'b1;
						st_d    = ST_DONE;
					end else begin
						idx_d   = idx_q + OP_IDX_W'(1);
						rd_addr = match_addr[ADDR_W-1:0];
					end
				end else begin
					st_d = ST_FCLASS;
				end
			end
			ST_FCLASS: begin
				pos_d = pos_inc;
				if (flags.lparen || flags.lbrack) begin
					kind_d  = flags.lparen ? KIND_PAREN : KIND_BRACK;
					depth_d = CNT_W'(1);
					rd_addr = pos_inc[ADDR_W-1:0];
					st_d    = (pos_inc >= len_q) ? ST_DONE : ST_FSKIP;
				end else begin
					st_d = ST_FCHECK;
				end
			end
			ST_FSKIP: begin
				depth_d = depth_fwd;
				pos_d   = pos_inc;
				rd_addr = pos_inc[ADDR_W-1:0];
				if (pos_inc >= len_q) begin
					st_d = ST_DONE;
				end else if (depth_fwd == '0) begin
					st_d = ST_FSPACE;
				end
			end
			ST_FSPACE: begin
				if (flags.space_eq) begin
					pos_d   = pos_inc;
					rd_addr = pos_inc[ADDR_W-1:0];
					if (pos_inc >= len_q) begin
						st_d = ST_DONE;
					end
				end else begin
					st_d = ST_FCHECK;
				end
			end
			ST_BPRE: begin
				if (pos_q > (len_q - CNT_W'(n_q))) begin
					pos_d  = pos_dec;
					kind_d = KIND_PAREN;
					st_d   = ST_BKIND;
				end else begin
					pre_d = 1'b0;
					st_d  = ST_BMSTART;
				end
			end
			ST_BKIND: begin
				st_d = (pos_q == '0) ? ST_DONE : ST_BKRD;
			end
			ST_BKRD: begin
				if (flags.close_eq) begin
					depth_d = CNT_W'(1);
					pos_d   = pos_dec;
					rd_addr = pos_dec[ADDR_W-1:0];
					st_d    = ST_BDEPTH;
				end else begin
					kind_d = KIND_BRACK;
					st_d   = kind_done_st;
				end
			end
			ST_BDEPTH: begin
				// The block ends on an opening bracket, so no spaces follow it backward.
				depth_d = depth_back;
				if (pos_q == '0) begin
					st_d = ST_DONE;
				end else if (depth_back == '0) begin
					kind_d = KIND_BRACK;
					st_d   = kind_done_st;
				end else begin
					pos_d   = pos_dec;
					rd_addr = pos_dec[ADDR_W-1:0];
				end
			end
			ST_BMSTART: begin
				idx_d = '0;
				st_d  = ST_BMATCH;
			end
			ST_BMATCH: begin
				if (flags.op_eq) begin
					if (idx_last) begin
						found_d = 1'b1;
						st_d    = ST_DONE;
					end else begin
						idx_d   = idx_q + OP_IDX_W'(1);
						rd_addr = match_addr[ADDR_W-1:0];
					end
				end else begin
					pos_d  = pos_dec;
					kind_d = KIND_PAREN;
					st_d   = ST_BKIND;
				end
			end
			ST_DONE: begin
				if (res_ack) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			pos_q   <= '0;
			depth_q <= '0;
			idx_q   <= '0;
			kind_q  <= KIND_PAREN;
			pre_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			pos_q   <= pos_d;
			depth_q <= depth_d;
			idx_q   <= idx_d;
			kind_q  <= kind_d;
			pre_q   <= pre_d;
			found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			len_q  <= len;
			n_q    <= op_n;
			last_q <= search_last;
		end
	end

	assign op_idx     = idx_q;
	assign kind       = kind_q;
	assign idle       = (st_q == ST_IDLE);
	assign res.valid  = (st_q == ST_DONE);
	assign res.found  = found_q;
	assign res.offset = found_q ? pos_q[OFFSET_W-1:0] : '0;

endmodule

// ----- hw/rtl/bracket_aware_operator_search.sv -----
// A character that is not the last is stored and the block is ready again.
// The last character starts a search on the store, one character read per cycle;
// each position is matched against the operator character by character, and a skipped block or
// its trailing spaces are read one character at a time; the result is registered.
// Throughput: one character per cycle while idle; none until a search's result is taken.
// Reset clears configuration (operator length 1) and counters, not the store or result data.
module bracket_aware_operator_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bao_pkg::PADDR_W-1:0] paddr,
	input  logic [bao_pkg::DATA_W-1:0]  pwdata,
	output logic [bao_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        char_valid,
	output logic                        char_ready,
	input  logic [bao_pkg::CHAR_W-1:0]  char_byte,
	input  logic                        last_char,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        found,
	output logic [bao_pkg::OFFSET_W-1:0] match_offset,
	output logic                        overflowed
);
	import bao_pkg::*;

	logic [OP_TEXT_W-1:0] op_text_q;
	logic [OP_LEN_W-1:0]  op_len_q;
	logic                 search_last_q;
	logic [OP_LEN_W-1:0]  op_n;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	logic [CNT_W-1:0]     char_count_q;
	logic                 overflow_q;
	logic                 store_full;
	logic                 char_acc;
	logic [CNT_W-1:0]     len_next;

	logic [ADDR_W-1:0]    rd_addr;
	logic [CHAR_W-1:0]    rdata;
	logic [OP_IDX_W-1:0]  op_idx;
	logic                 kind;
	logic                 seq_idle;
	cmp_flags_t           flags;
	seq_res_t             seq_res;
	logic                 res_ack;

	logic                 result_valid_q;
	logic                 found_q;
	logic [OFFSET_W-1:0]  match_offset_q;
	logic                 overflowed_q;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_OP_TEXT:     prdata = op_text_q;
			REG_OP_LENGTH:   prdata = DATA_W'(op_len_q);
			REG_SEARCH_LAST: prdata = DATA_W'(search_last_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_text_q     <= '0;
			op_len_q      <= OP_LEN_W'(1);
			search_last_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_OP_TEXT:     op_text_q     <= pwdata[OP_TEXT_W-1:0];
				REG_OP_LENGTH:   op_len_q      <= pwdata[OP_LEN_W-1:0];
				REG_SEARCH_LAST: search_last_q <= pwdata[0];
				default:         ;
			endcase
		end
	end

	// Zero counts as one character, anything above the maximum as the maximum.
	always_comb begin
		if (op_len_q == '0) begin
			op_n = OP_LEN_W'(1);
		end else if (op_len_q > OP_LEN_W'(MAX_OP_LEN)) begin
			op_n = OP_LEN_W'(MAX_OP_LEN);
		end else begin
			op_n = op_len_q;
		end
	end

	// Loading. A character that arrives with the store full is dropped and flagged.
	assign char_ready = seq_idle;
	assign char_acc   = char_valid && char_ready;
	assign store_full = (char_count_q == CNT_W'(EXPR_DEPTH));
	assign len_next   = store_full ? char_count_q : char_count_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (res_ack) begin
			char_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (char_acc) begin
			char_count_q <= len_next;
			if (store_full) begin
				overflow_q <= 1'b1;
			end
		end
	end

	bao_store u_store (
		.clk   (clk),
		.we    (char_acc && !store_full),
		.waddr (char_count_q[ADDR_W-1:0]),
		.wdata (char_byte),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	bao_cmp u_cmp (
		.ch      (rdata),
		.op_text (op_text_q),
		.op_idx  (op_idx),
		.kind    (kind),
		.flags   (flags)
	);

	bao_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (char_acc && last_char),
		.len         (len_next),
		.op_n        (op_n),
		.search_last (search_last_q),
		.flags       (flags),
		.res_ack     (res_ack),
		.rd_addr     (rd_addr),
		.op_idx      (op_idx),
		.kind        (kind),
		.idle        (seq_idle),
		.res         (seq_res)
	);

	// Output register; the sequencer holds its result until this register is free.
	assign res_ack = seq_res.valid && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ack) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			found_q        <= seq_res.found;
			match_offset_q <= seq_res.offset;
			overflowed_q   <= overflow_q;
		end
	end

	assign result_valid = result_valid_q;
	assign found        = found_q;
	assign match_offset = match_offset_q;
	assign overflowed   = overflowed_q;

endmodule
